@@ sv/brb_pkg.sv @@
// Shared types and constants of the byte ring buffer with peek.
package brb_pkg;

   localparam int DATA_W      = 8;
   localparam int LEN_W       = 7;
   localparam int CNT_W       = 13;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int SIZE_RESET  = 4096;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_PEEK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_READ_REFUSED  = 2'd1,
      ST_WRITE_REFUSED = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BUFFER_SIZE = 1'd0,
      REG_OVERWRITE   = 1'd1
   } reg_index_type;

   // Metadata of one response, handed from the control to the output stage.
   typedef struct packed {
      logic             last;
      status_type       status;
      logic [CNT_W-1:0] fill;
      logic             from_ram;
   } rsp_meta_type;

endpackage

@@ sv/byte_ring_buffer_with_peek.sv @@
// Top level of the byte ring buffer with programmable size and peek reads.
//
// Request channel (req_*): one request is one write byte, one read run or one
// peek run, taken when req_tvalid and req_tready are both high. Every write
// gives one response; a read or peek of N bytes gives N responses, tlast on
// the final one; a refused read gives one error response; a run of length
// zero and the unused op code give none.
// Response channel (rsp_*): one output register. A write's response shows the
// next cycle. A read run is first accepted, then issues one byte per cycle
// while the output register is free, set by the single RAM read port; each
// byte shows the cycle after its read is issued.
// When the sink stalls, the held response stays put, reads pause, and no new
// request is taken until the output register can accept a response.
// CSR port: csr_we writes register csr_index (0 size, 1 overwrite policy).
// Writing the size resets the positions and the fill count and starts a
// clearing pass over the store.
// Reset (synchronous, active high) loads the default size, the denied policy
// and starts the clearing pass. The pass writes zeros to all STORE_DEPTH
// entries, one per cycle; requests are held off until the pass ends.
module byte_ring_buffer_with_peek #(
   parameter int STORE_DEPTH = 4096,
   parameter int MAX_RUN     = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata: data_in [7:0], run_length [14:8], zero [15]
   input  logic [brb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: op [1:0], run_first [2]
   input  logic [brb_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: data_out [7:0], fill_count [20:8], zero [23:21]
   output logic [brb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // rsp_tuser: status [1:0]
   output logic [brb_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                             csr_we,
   input  logic [brb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [brb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import brb_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   // Width that holds a position plus one and any active size
   localparam int PW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
   localparam logic [CNT_W-1:0] SIZE_INIT =
      CNT_W'((SIZE_RESET > STORE_DEPTH) ? STORE_DEPTH : SIZE_RESET);
   localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);
   localparam logic [LEN_W-1:0] RUN_MAX = LEN_W'(MAX_RUN);

   // Clamp a written size into the usable range
   function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] raw);
      logic [CNT_W-1:0] s;
      s = raw;
      if (raw == '0) begin
         s = CNT_W'(1);
      end else if (32'(raw) > 32'(STORE_DEPTH)) begin
         s = CNT_W'(STORE_DEPTH);
      end
      return s;
   endfunction

   // Advance a position by one, wrapping at the active size
   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
                                              input logic [CNT_W-1:0] sz);
      logic [PW-1:0] nxt;
      nxt = PW'(p) + PW'(1);
      return (nxt == PW'(sz)) ? '0 : nxt[AW-1:0];
   endfunction

   logic [CNT_W-1:0] size_ff, size_in;
   logic             allow_ff, allow_in;
   logic [AW-1:0]    rp_ff, rp_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [CNT_W-1:0] unread_ff, unread_in;
   logic             rejected_ff, rejected_in;
   logic             clr_busy_ff, clr_busy_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             rd_busy_ff, rd_busy_in;
   logic [LEN_W-1:0] rd_left_ff, rd_left_in;
   logic [AW-1:0]    rd_pos_ff, rd_pos_in;
   logic             rd_consume_ff, rd_consume_in;

   op_type            op;
   logic [DATA_W-1:0] data_in;
   logic [LEN_W-1:0]  len_raw, len;
   logic [CNT_W-1:0]  len_x;
   logic              run_first;
   logic              denied;
   logic              req_fire;
   logic              rsp_free;
   logic              first_rej, wr_rej, rd_refuse;
   logic [AW-1:0]     rd_next;

   logic              rsp_load;
   rsp_meta_type      rsp_meta;
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   // Unpack the request
   assign data_in   = req_tdata[DATA_W-1:0];
   assign len_raw   = req_tdata[DATA_W +: LEN_W];
   assign op        = op_type'(req_tuser[1:0]);
   assign run_first = req_tuser[2];
   assign len       = (len_raw > RUN_MAX) ? RUN_MAX : len_raw;
   assign len_x     = CNT_W'(len);
   assign denied    = !allow_ff;

   assign req_tready = !clr_busy_ff && !rd_busy_ff && rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   // Space check on the first byte of a run; later bytes inherit the verdict,
   // and a byte that still finds the store full in the denied policy is dropped
   assign first_rej = run_first ? (denied && (len_x > size_ff || len_x > size_ff - unread_ff))
                                : rejected_ff;
   assign wr_rej    = first_rej || (denied && unread_ff >= size_ff);
   assign rd_refuse = denied && (len_x > size_ff || len_x > unread_ff);
   assign rd_next   = wrap_inc(rd_pos_ff, size_ff);

   always_comb begin
      size_in       = size_ff;
      allow_in      = allow_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      unread_in     = unread_ff;
      rejected_in   = rejected_ff;
      clr_busy_in   = clr_busy_ff;
      clr_addr_in   = clr_addr_ff;
      rd_busy_in    = rd_busy_ff;
      rd_left_in    = rd_left_ff;
      rd_pos_in     = rd_pos_ff;
      rd_consume_in = rd_consume_ff;
      ram_we        = 1'b0;
      ram_waddr     = wp_ff;
      ram_wdata     = data_in;
      ram_re        = 1'b0;
      ram_raddr     = rd_pos_ff;
      rsp_load      = 1'b0;
      rsp_meta      = '{last: 1'b1, status: ST_OK, fill: unread_ff, from_ram: 1'b0};

      // Clearing pass: zero one entry per cycle
      if (clr_busy_ff) begin
         ram_we      = 1'b1;
         ram_waddr   = clr_addr_ff;
         ram_wdata   = '0;
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == CLR_LAST) begin
            clr_busy_in = 1'b0;
         end
      end

      // Read sequencer: issue one byte whenever the output slot frees
      if (rd_busy_ff && rsp_free) begin
         ram_re     = 1'b1;
         rsp_load   = 1'b1;
         rsp_meta   = '{last: (rd_left_ff == LEN_W'(1)), status: ST_OK,
                        fill: unread_ff, from_ram: 1'b1};
         rd_pos_in  = rd_next;
         rd_left_in = rd_left_ff - LEN_W'(1);
         if (rd_left_ff == LEN_W'(1)) begin
            rd_busy_in = 1'b0;
            if (rd_consume_ff) begin
               rp_in = rd_next;
            end
         end
      end

      if (req_fire) begin
         unique case (op) inside
            OP_WRITE: begin
               rejected_in = wr_rej;
               rsp_load    = 1'b1;
               if (wr_rej) begin
                  rsp_meta = '{last: 1'b1, status: ST_WRITE_REFUSED,
                               fill: unread_ff, from_ram: 1'b0};
               end else begin
                  ram_we    = 1'b1;
                  wp_in     = wrap_inc(wp_ff, size_ff);
                  unread_in = (unread_ff == size_ff) ? size_ff : unread_ff + CNT_W'(1);
                  rsp_meta  = '{last: 1'b1, status: ST_OK, fill: unread_in, from_ram: 1'b0};
               end
            end
            OP_READ, OP_PEEK: begin
               if (len != '0) begin
                  if (rd_refuse) begin
                     rsp_load = 1'b1;
                     rsp_meta = '{last: 1'b1, status: ST_READ_REFUSED,
                                  fill: unread_ff, from_ram: 1'b0};
                  end else begin
                     rd_busy_in    = 1'b1;
                     rd_left_in    = len;
                     rd_pos_in     = rp_ff;
                     rd_consume_in = (op == OP_READ);
                     if (op == OP_READ) begin
                        // Floor the fill count at zero on overread
                        unread_in = (len_x >= unread_ff) ? '0 : unread_ff - len_x;
                     end
                  end
               end
            end
            default: begin
               // unused op: drop the request
            end
         endcase
      end

      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_BUFFER_SIZE: begin
               size_in     = clamp_size(csr_wdata);
               rp_in       = '0;
               wp_in       = '0;
               unread_in   = '0;
               rejected_in = 1'b0;
               clr_busy_in = 1'b1;
               clr_addr_in = '0;
            end
            REG_OVERWRITE: begin
               allow_in = csr_wdata[0];
            end
            default: begin
               // no other registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_INIT;
         allow_ff    <= 1'b0;
         rp_ff       <= '0;
         wp_ff       <= '0;
         unread_ff   <= '0;
         rejected_ff <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         rd_busy_ff  <= 1'b0;
      end else begin
         size_ff     <= size_in;
         allow_ff    <= allow_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         unread_ff   <= unread_in;
         rejected_ff <= rejected_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         rd_busy_ff  <= rd_busy_in;
      end
      rd_left_ff    <= rd_left_in;
      rd_pos_ff     <= rd_pos_in;
      rd_consume_ff <= rd_consume_in;
   end

   brb_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   brb_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .meta      (rsp_meta),
      .ram_rdata (ram_rdata),
      .free      (rsp_free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ sv/brb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/brb_rsp_stage.sv @@
// Response output register: holds one response until the sink takes it.
module brb_rsp_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  brb_pkg::rsp_meta_type            meta,
   input  logic [brb_pkg::DATA_W-1:0]       ram_rdata,
   output logic                             free,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: data_out [7:0], fill_count [20:8], zero [23:21]
   output logic [brb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // rsp_tuser: status [1:0]
   output logic [brb_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import brb_pkg::*;

   logic         valid_ff, valid_in;
   rsp_meta_type meta_ff;
   logic [DATA_W-1:0] data_out;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         meta_ff <= meta;
      end
   end

   // RAM read data holds while stalled, since no read issues until this slot frees
   assign data_out   = meta_ff.from_ram ? ram_rdata : '0;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = meta_ff.last;
   assign rsp_tuser  = RSP_TUSER_W'(meta_ff.status);
   assign rsp_tdata  = {(RSP_TDATA_W - CNT_W - DATA_W)'(0), meta_ff.fill, data_out};

endmodule

@@ bench/ring_buffer_checker.sv @@
// Checker for the byte ring buffer: shadow store, response forecast and field compare.
module ring_buffer_checker #(
   parameter int STORE_DEPTH = 4096,
   parameter int MAX_RUN     = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // req_tdata: data_in [7:0], run_length [14:8], zero [15]
   input  logic [brb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: op [1:0], run_first [2]
   input  logic [brb_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: data_out [7:0], fill_count [20:8], zero [23:21]
   input  logic [brb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   // rsp_tuser: status [1:0]
   input  logic [brb_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                            csr_we,
   input  logic [brb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              expected_left
);
   timeunit 1ns;
   timeprecision 1ps;

   import brb_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
      status_type        status;
      logic [CNT_W-1:0]  fill;
   } byte_result_type;

   byte_result_type   due_responses[$];
   logic [DATA_W-1:0] shadow_store [STORE_DEPTH];
   int                rd_ptr;
   int                wr_ptr;
   int                held;
   bit                run_dropped;
   logic [CNT_W-1:0]  size_reg;
   bit                overwrite_on;
   int                mismatches = 0;
   int                queued = 0;

   assign fail_count    = mismatches;
   assign expected_left = queued;

   // Size in use: zero acts as one, anything past the store depth as the depth.
   function automatic int span();
      int s;
      s = size_reg;
      if (s == 0) s = 1;
      if (s > STORE_DEPTH) s = STORE_DEPTH;
      return s;
   endfunction

   task automatic wipe_store();
      for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = '0;
      rd_ptr      = 0;
      wr_ptr      = 0;
      held        = 0;
      run_dropped = 1'b0;
   endtask

   task automatic queue_result(logic [DATA_W-1:0] data, logic last, status_type st);
      byte_result_type r;
      r.data   = data;
      r.last   = last;
      r.status = st;
      r.fill   = held[CNT_W-1:0];
      due_responses.push_back(r);
   endtask

   task automatic apply_register();
      if (csr_index == REG_BUFFER_SIZE) begin
         size_reg = csr_wdata;
         wipe_store();
      end else if (csr_index == REG_OVERWRITE) begin
         overwrite_on = csr_wdata[0];
      end
   endtask

   task automatic forecast_request();
      logic [1:0]        op;
      logic [DATA_W-1:0] din;
      int                len;
      bit                first;
      int                sz;
      int                pos;
      bit                denied;
      status_type        st;
      op     = req_tuser[1:0];
      first  = req_tuser[2];
      din    = req_tdata[DATA_W-1:0];
      len    = req_tdata[DATA_W +: LEN_W];
      sz     = span();
      denied = !overwrite_on;
      if (rd_ptr >= sz) rd_ptr = 0;
      if (wr_ptr >= sz) wr_ptr = 0;
      if (len > MAX_RUN) len = MAX_RUN;

      if (op == OP_WRITE) begin
         st = ST_OK;
         if (first) begin
            run_dropped = 1'b0;
            if (denied && (len > sz || len > sz - ((held > sz) ? sz : held)))
               run_dropped = 1'b1;
         end
         if (!run_dropped && denied && held >= sz) run_dropped = 1'b1;
         if (run_dropped) begin
            st = ST_WRITE_REFUSED;
         end else begin
            shadow_store[wr_ptr] = din;
            wr_ptr++;
            if (wr_ptr >= sz) wr_ptr = 0;
            held++;
            if (held > sz) held = sz;
         end
         queue_result('0, 1'b1, st);
      end else if ((op == OP_READ || op == OP_PEEK) && len != 0) begin
         if (denied && (len > sz || len > held)) begin
            queue_result('0, 1'b1, ST_READ_REFUSED);
         end else begin
            pos = rd_ptr;
            if (op == OP_READ) begin
               rd_ptr = (rd_ptr + len) % sz;
               held   = (len >= held) ? 0 : held - len;
            end
            for (int i = 0; i < len; i++) begin
               queue_result(shadow_store[pos], (i + 1 == len), ST_OK);
               pos++;
               if (pos >= sz) pos = 0;
            end
         end
      end
   endtask

   task automatic check_response();
      byte_result_type  want;
      logic [CNT_W-1:0] got_fill;
      got_fill = rsp_tdata[DATA_W +: CNT_W];
      if (due_responses.size() == 0) begin
         $error("unexpected response: data_out %0d, fill_count %0d, status %0d",
                rsp_tdata[DATA_W-1:0], got_fill, rsp_tuser);
         mismatches++;
      end else begin
         want = due_responses.pop_front();
         if (rsp_tdata[DATA_W-1:0] !== want.data) begin
            $error("data_out: expected %0d, actual %0d", want.data, rsp_tdata[DATA_W-1:0]);
            mismatches++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
            mismatches++;
         end
         if (rsp_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
            mismatches++;
         end
         if (got_fill !== want.fill) begin
            $error("fill_count: expected %0d, actual %0d", want.fill, got_fill);
            mismatches++;
         end
      end
   endtask

   // Compare before forecasting: a response never belongs to a request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         size_reg     = CNT_W'(SIZE_RESET);
         overwrite_on = 1'b0;
         wipe_store();
         due_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (csr_we) apply_register();
         if (req_tvalid && req_tready) forecast_request();
      end
      queued <= due_responses.size();
   end

endmodule

@@ bench/testbench.sv @@
// Top of the byte ring buffer bench: clock, reset, stimulus, sink pacing and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import brb_pkg::*;

   localparam int         MAX_RUN      = 64;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         QUIET_CYCLES = 8;
   // Limit set well above the slowest legal run.
   localparam int         CYCLE_LIMIT  = 4_000_000;
   // Op code the block must ignore.
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int fail_count;
   int expected_left;
   int cycle_count = 0;
   int burst_left  = 8;
   bit req_up      = 1'b0;   // request valid currently driven high
   bit hold_wanted = 1'b0;   // stimulus asks the sink for a long hold-off
   bit holding     = 1'b0;   // sink is inside that hold-off

   byte_ring_buffer_with_peek dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ring_buffer_checker ring_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   always #6 clock = ~clock;

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Sink pacing: stretches of always ready, random ready, a fixed pattern or a
   // short stall; on request a long hold-off counted here.
   initial begin
      int stretch;
      int style;
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            holding     = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_tready <= 1'b0;
            end
            holding = 1'b0;
         end else begin
            style   = $urandom_range(0, 4);
            stretch = (style == 4) ? $urandom_range(1, 12) : $urandom_range(1, 40);
            for (int k = 0; k < stretch; k++) begin
               @(posedge clock);
               case (style)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= ($urandom_range(0, 3) != 0);
                  3: rsp_tready <= (k % 3 == 0);
                  default: rsp_tready <= 1'b0;
               endcase
            end
         end
      end
   end

   // Offer one request and hold it until taken; the sender works in bursts,
   // so drop valid for a random gap when the current burst runs out.
   task automatic send_request(logic [1:0] op, int data, int len, int first);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, 7'(len), 8'(data)};
      req_tuser  <= {1'(first), op};
      req_up = 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         // Now and then a long burst with no idling at all.
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         req_up = 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Send a write run of 'sent' bytes that announces 'announced' bytes.
   task automatic write_run(int announced, int sent);
      for (int i = 0; i < sent; i++)
         send_request(OP_WRITE, $urandom_range(0, 255), announced, (i == 0));
   endtask

   // Drop valid so the last request is not taken twice.
   task automatic release_valid();
      if (req_up) begin
         req_tvalid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // Pause the sender until every forecast response has arrived, then let
   // requests without responses finish inside the block.
   task automatic settle();
      release_valid();
      do @(posedge clock); while (expected_left != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write one register; then hold the enable low across a clock edge so that
   // back-to-back writes never stack two assignments in one step.
   task automatic set_register(reg_index_type idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed runs and in-range reads, with broken runs and noise.
   task automatic random_phase(int target, int cap);
      int         done;
      int         pick;
      int         len;
      int         sent;
      logic [1:0] rd_op;
      done = 0;
      while (done < target) begin
         pick  = $urandom_range(0, 99);
         rd_op = $urandom_range(0, 1) ? OP_READ : OP_PEEK;
         if (pick < 45) begin
            len = $urandom_range(1, cap);
            write_run(len, len);
            done += len;
         end else if (pick < 78) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_RUN)
                                              : $urandom_range(1, cap);
            send_request(rd_op, $urandom_range(0, 255), len, $urandom_range(0, 1));
            done++;
         end else if (pick < 90) begin
            // run longer or shorter than announced, sometimes a stray byte after it
            len  = $urandom_range(1, cap);
            sent = $urandom_range(0, 1) ? len + $urandom_range(1, 3) : $urandom_range(1, len);
            write_run(len, sent);
            done += sent;
            if ($urandom_range(0, 3) == 0) begin
               send_request(OP_WRITE, $urandom_range(0, 255), len, 1'b0);
               done++;
            end
         end else begin
            case ($urandom_range(0, 3))
               0: send_request(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 127),
                               $urandom_range(0, 1));
               1: send_request(rd_op, $urandom_range(0, 255), 0, $urandom_range(0, 1));
               2: begin
                  send_request(rd_op, $urandom_range(0, 255), $urandom_range(MAX_RUN + 1, 127),
                               $urandom_range(0, 1));
                  done++;
               end
               default: begin
                  sent = $urandom_range(1, 3);
                  write_run($urandom_range(MAX_RUN + 1, 127), sent);
                  done += sent;
               end
            endcase
         end
         if ($urandom_range(0, 49) == 0) settle();
      end
   endtask

   // Reconfigure while idle: policy first, then the size, which clears the store.
   task automatic run_phase(bit allow, int size, int target);
      settle();
      set_register(REG_OVERWRITE, allow);
      set_register(REG_BUFFER_SIZE, size);
      random_phase(target, (size < MAX_RUN) ? size : MAX_RUN);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Default size, denied policy: a read of an empty store is refused.
      send_request(OP_READ, 8'h00, 1, 1'b0);
      // Zero length peek and the unused op give no responses.
      send_request(OP_PEEK, 8'h00, 0, 1'b0);
      send_request(OP_UNUSED, 8'hC3, 127, 1'b1);
      // Three-byte run with the data extremes, then peek it.
      send_request(OP_WRITE, 8'h00, 3, 1'b1);
      send_request(OP_WRITE, 8'hFF, 3, 1'b0);
      send_request(OP_WRITE, 8'h5A, 3, 1'b0);
      send_request(OP_PEEK, 8'h00, 3, 1'b0);
      // Length past the run cap saturates and exceeds the fill: refused.
      send_request(OP_READ, 8'hFF, 127, 1'b0);
      send_request(OP_READ, 8'h00, 2, 1'b0);
      send_request(OP_READ, 8'h00, 1, 1'b0);

      settle();
      set_register(REG_BUFFER_SIZE, 2);
      // Run announced longer than the size: drop every byte of it.
      send_request(OP_WRITE, 8'h11, 3, 1'b1);
      send_request(OP_WRITE, 8'h22, 3, 1'b0);
      // Zero length run passes the check; its third byte finds the store full.
      send_request(OP_WRITE, 8'h33, 0, 1'b1);
      send_request(OP_WRITE, 8'h44, 0, 1'b0);
      send_request(OP_WRITE, 8'h55, 0, 1'b0);
      send_request(OP_READ, 8'h00, 2, 1'b0);

      settle();
      set_register(REG_OVERWRITE, 1);
      // Overwrite policy: the third byte replaces old data, then overread and wrap.
      send_request(OP_WRITE, 8'hA1, 64, 1'b1);
      send_request(OP_WRITE, 8'hA2, 64, 1'b0);
      send_request(OP_WRITE, 8'hA3, 64, 1'b0);
      send_request(OP_READ, 8'h00, 5, 1'b0);
      send_request(OP_PEEK, 8'h00, 64, 1'b0);

      // Size zero behaves as one byte.
      settle();
      set_register(REG_BUFFER_SIZE, 0);
      send_request(OP_WRITE, 8'h7E, 1, 1'b1);
      send_request(OP_PEEK, 8'h00, 2, 1'b0);

      // Size past the store depth behaves as the full depth.
      settle();
      set_register(REG_BUFFER_SIZE, 13'h1FFF);
      send_request(OP_WRITE, 8'h81, 1, 1'b1);
      send_request(OP_READ, 8'h00, 1, 1'b0);

      run_phase(1'b0, SIZE_RESET, 60);

      // Long sink hold-off while the sender keeps offering: fill the output
      // path until the block stalls its input.
      release_valid();
      hold_wanted = 1'b1;
      do @(posedge clock); while (!holding);
      send_request(OP_PEEK, 8'h00, MAX_RUN, 1'b0);
      write_run(24, 24);

      run_phase(1'b0, 1, 45);
      run_phase(1'b1, 1, 45);
      run_phase(1'b1, MAX_RUN, 55);
      run_phase(1'b1, SIZE_RESET, 55);
      run_phase(1'b0, $urandom_range(2, MAX_RUN - 1), 55);
      run_phase(1'b1, $urandom_range(MAX_RUN + 1, 700), 55);
      run_phase(1'b0, 3, 45);

      settle();
      if (fail_count == 0 && expected_left == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
